// ===== sv/rfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB fade and schedule controller package
// Shared types, register map, operation codes and reset values.
// ----------------------------------------------------------------------------
package rfsc_pkg;

    // Default number of intensity steps from dark to full.
    localparam int DEF_INTENSITY_STEPS = 1000;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_BASE_COLOR      = 3'd0;
    localparam logic [IDX_W-1:0] REG_SATURATION      = 3'd1;
    localparam logic [IDX_W-1:0] REG_BRIGHTNESS      = 3'd2;
    localparam logic [IDX_W-1:0] REG_ON_MINUTE       = 3'd3;
    localparam logic [IDX_W-1:0] REG_OFF_MINUTE      = 3'd4;
    localparam logic [IDX_W-1:0] REG_SCHEDULE_ENABLE = 3'd5;
    localparam logic [IDX_W-1:0] REG_FADE_PERIOD     = 3'd6;

    // Register reset values.
    localparam logic [23:0] RST_BASE_COLOR = 24'h2959FC;
    localparam logic [7:0]  RST_SATURATION = 8'd128;
    localparam logic [7:0]  RST_BRIGHTNESS = 8'd128;

    // Input operation codes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_CLOCK = 2'd1;
    localparam logic [1:0] OP_POWER = 2'd2;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register file contents.
    typedef struct packed {
        logic [23:0] base_color;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
        logic [10:0] on_minute;
        logic [10:0] off_minute;
        logic        schedule_enable;
        logic [15:0] fade_period;
    } cfg_t;

    // Classified command kinds.
    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_CLOCK = 2'd1,
        K_POWER = 2'd2,
        K_NOP   = 2'd3
    } cmd_kind_t;

    // One classified command as it travels through the queue.
    typedef struct packed {
        cmd_kind_t kind;
        logic      match_on;
        logic      match_off;
        logic      power;
    } cmd_t;

endpackage

// ===== sv/rgb_fade_schedule_controller_top.sv =====
// ----------------------------------------------------------------------------
// RGB fade and schedule controller
// Ticks, clock reports and power commands drive a fade of three PWM duties.
// ----------------------------------------------------------------------------
//  Channel   Handshake                      Payload
//  input     in_valid / in_ready            op, hour, minute, clock_valid,
//                                           power_command
//  result    out_valid / out_ready          red_duty, green_duty, blue_duty,
//                                           power_state, fading, intensity_level
//  config    psel / penable / pready        paddr, pwrite, pwdata, prdata
//
//  Each transaction goes from queue to result register through one state
//  update, three multiply stages, a reciprocal quotient estimate and a
//  one-step correction per color lane. The back end takes no new
//  transaction until its result is loaded, which waits on a stalled result.
//  The input enters a two-entry command queue the cycle it is accepted, so
//  in_ready only drops while that queue is full.
//  A waiting result does not stop the next transaction from being queued.
//  Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_fade_schedule_controller_top #(
    parameter int INTENSITY_STEPS = rfsc_pkg::DEF_INTENSITY_STEPS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [4:0]                   hour,
    input  logic [5:0]                   minute,
    input  logic                         clock_valid,
    input  logic                         power_command,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   red_duty,
    output logic [7:0]                   green_duty,
    output logic [7:0]                   blue_duty,
    output logic                         power_state,
    output logic                         fading,
    output logic [9:0]                   intensity_level,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rfsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [rfsc_pkg::DATA_W-1:0]  pwdata,
    output logic [rfsc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import rfsc_pkg::*;

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;

    // Configuration registers.
    rfsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input classification.
    rfsc_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .hour          (hour),
        .minute        (minute),
        .clock_valid   (clock_valid),
        .power_command (power_command),
        .cfg           (cfg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    // Command queue.
    rfsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    // Fade state and duty computation.
    rfsc_back #(
        .INTENSITY_STEPS (INTENSITY_STEPS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_valid         (q_valid),
        .q_cmd           (pop_cmd),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .red_duty        (red_duty),
        .green_duty      (green_duty),
        .blue_duty       (blue_duty),
        .power_state     (power_state),
        .fading          (fading),
        .intensity_level (intensity_level)
    );

endmodule

// ===== sv/rfsc_regs.sv =====
// ----------------------------------------------------------------------------
// RGB fade controller configuration registers
// APB-style register file holding color, schedule and fade settings.
// ----------------------------------------------------------------------------
module rfsc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rfsc_pkg::DATA_W-1:0]   pwdata,
    output logic [rfsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rfsc_pkg::cfg_t                cfg
);
    import rfsc_pkg::*;

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes keep only each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_color      <= RST_BASE_COLOR;
            cfg_reg.saturation      <= RST_SATURATION;
            cfg_reg.brightness      <= RST_BRIGHTNESS;
            cfg_reg.on_minute       <= '0;
            cfg_reg.off_minute      <= '0;
            cfg_reg.schedule_enable <= 1'b0;
            cfg_reg.fade_period     <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_BASE_COLOR:      cfg_reg.base_color      <= pwdata[23:0];
                REG_SATURATION:      cfg_reg.saturation      <= pwdata[7:0];
                REG_BRIGHTNESS:      cfg_reg.brightness      <= pwdata[7:0];
                REG_ON_MINUTE:       cfg_reg.on_minute       <= pwdata[10:0];
                REG_OFF_MINUTE:      cfg_reg.off_minute      <= pwdata[10:0];
                REG_SCHEDULE_ENABLE: cfg_reg.schedule_enable <= pwdata[0];
                REG_FADE_PERIOD:     cfg_reg.fade_period     <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    // Read data multiplexer.
    always_comb
    begin
        case (idx)
            REG_BASE_COLOR:      prdata = DATA_W'(cfg_reg.base_color);
            REG_SATURATION:      prdata = DATA_W'(cfg_reg.saturation);
            REG_BRIGHTNESS:      prdata = DATA_W'(cfg_reg.brightness);
            REG_ON_MINUTE:       prdata = DATA_W'(cfg_reg.on_minute);
            REG_OFF_MINUTE:      prdata = DATA_W'(cfg_reg.off_minute);
            REG_SCHEDULE_ENABLE: prdata = DATA_W'(cfg_reg.schedule_enable);
            REG_FADE_PERIOD:     prdata = DATA_W'(cfg_reg.fade_period);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== sv/rfsc_front.sv =====
// ----------------------------------------------------------------------------
// RGB fade controller front end
// Accepts input transactions and classifies them into queue commands.
// ----------------------------------------------------------------------------
module rfsc_front (
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      op,
    input  logic [4:0]      hour,
    input  logic [5:0]      minute,
    input  logic            clock_valid,
    input  logic            power_command,
    input  rfsc_pkg::cfg_t  cfg,
    input  logic            q_full,
    output logic            q_push,
    output rfsc_pkg::cmd_t  q_cmd
);
    import rfsc_pkg::*;

    logic [10:0] minute_of_day;
    logic        sched_ok;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    // Minute of day is taken as given, with no wrap.
    assign minute_of_day = 11'(hour) * 11'd60 + 11'(minute);
    assign sched_ok      = clock_valid && cfg.schedule_enable;

    // Classify the operation; schedule matches are resolved against state later.
    always_comb
    begin
        q_cmd.kind      = K_NOP;
        q_cmd.match_on  = 1'b0;
        q_cmd.match_off = 1'b0;
        q_cmd.power     = power_command;
        case (op)
            OP_TICK:
            begin
                q_cmd.kind = K_TICK;
            end
            OP_CLOCK:
            begin
                q_cmd.kind      = K_CLOCK;
                q_cmd.match_on  = sched_ok && (minute_of_day == cfg.on_minute);
                q_cmd.match_off = sched_ok && (minute_of_day == cfg.off_minute);
            end
            OP_POWER:
            begin
                q_cmd.kind = K_POWER;
            end
            default:
            begin
                q_cmd.kind = K_NOP;
            end
        endcase
    end

endmodule

// ===== sv/rfsc_queue.sv =====
// ----------------------------------------------------------------------------
// RGB fade controller command queue
// Small FIFO decoupling the classifying front from the executing back.
// ----------------------------------------------------------------------------
module rfsc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rfsc_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output rfsc_pkg::cmd_t  pop_cmd
);
    import rfsc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == FULL_CNT);
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/rfsc_back.sv =====
// ----------------------------------------------------------------------------
// RGB fade controller back end
// Applies commands to the fade state and computes the three PWM duties.
// ----------------------------------------------------------------------------
module rfsc_back #(
    parameter int INTENSITY_STEPS = rfsc_pkg::DEF_INTENSITY_STEPS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rfsc_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  rfsc_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      red_duty,
    output logic [7:0]      green_duty,
    output logic [7:0]      blue_duty,
    output logic            power_state,
    output logic            fading,
    output logic [9:0]      intensity_level
);
    import rfsc_pkg::*;

    localparam int INT_W  = $clog2(INTENSITY_STEPS + 1);
    localparam int D_W    = 17;
    localparam int DV_W   = 25;
    localparam int NUM_W  = DV_W + INT_W;
    localparam int TICK_W = 17;
    localparam logic [INT_W-1:0] STEPS = INT_W'(INTENSITY_STEPS);

    // Divisor 65025 * steps and its reciprocal. The numerator is cut to its top
    // bits and multiplied by the reciprocal; both errors stay below one half,
    // so the estimate is the quotient or one less.
    localparam longint unsigned DIVISOR = 64'd65025 * 64'(INTENSITY_STEPS);
    localparam int REC_SH = $clog2(DIVISOR * 64'd255 + 64'd1) + 1;
    localparam int TOP_SH = $clog2(DIVISOR) - 2;
    localparam int EST_SH = REC_SH - TOP_SH;
    localparam int TOP_W  = NUM_W - TOP_SH;
    localparam longint unsigned RECIP = (64'd1 << REC_SH) / DIVISOR;
    localparam int REC_W  = $clog2(RECIP + 64'd1);
    localparam int PROD_W = TOP_W + REC_W;
    localparam logic [REC_W-1:0] RECIP_C = REC_W'(RECIP);
    localparam logic [NUM_W-1:0] DIV_N   = NUM_W'(DIVISOR);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL1 = 7'b0000010,
        ST_MUL2 = 7'b0000100,
        ST_MUL3 = 7'b0001000,
        ST_EST  = 7'b0010000,
        ST_FIX  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t            state_reg;
    logic              power_reg;
    logic              power_next;
    logic              fade_reg;
    logic              fade_next;
    logic [INT_W-1:0]  int_reg;
    logic [INT_W-1:0]  int_next;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;
    logic [TICK_W-1:0] tick_inc;
    logic              out_valid_reg;
    logic              out_load;

    logic [7:0]        chan      [3];
    logic [D_W-1:0]    d_calc    [3];
    logic [D_W-1:0]    d_reg     [3];
    logic [DV_W-1:0]   dv_reg    [3];
    logic [NUM_W-1:0]  num_reg   [3];
    logic [PROD_W-1:0] est_prod  [3];
    logic [NUM_W-1:0]  fix_rem   [3];
    logic [7:0]        q_reg     [3];
    logic [7:0]        duty_reg  [3];
    logic              out_power_reg;
    logic              out_fade_reg;
    logic [9:0]        out_int_reg;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Apply one command to the fade state, then the end-of-fade check.
    always_comb
    begin
        power_next = power_reg;
        fade_next  = fade_reg;
        int_next   = int_reg;
        tick_next  = tick_reg;
        tick_inc   = (tick_reg != '1) ? tick_reg + 1'b1 : tick_reg;
        case (q_cmd.kind)
            K_TICK:
            begin
                if (fade_reg)
                begin
                    if (tick_inc > {1'b0, cfg.fade_period})
                    begin
                        if (power_reg)
                        begin
                            if (int_reg < STEPS)
                            begin
                                int_next = int_reg + 1'b1;
                            end
                        end
                        else if (int_reg != '0)
                        begin
                            int_next = int_reg - 1'b1;
                        end
                        tick_next = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            K_CLOCK:
            begin
                if (!fade_reg)
                begin
                    if (q_cmd.match_on && !power_next)
                    begin
                        power_next = 1'b1;
                        fade_next  = 1'b1;
                        tick_next  = '0;
                    end
                    if (q_cmd.match_off && power_next)
                    begin
                        power_next = 1'b0;
                        fade_next  = 1'b1;
                        tick_next  = '0;
                    end
                end
            end
            K_POWER:
            begin
                power_next = q_cmd.power;
                fade_next  = 1'b1;
                tick_next  = '0;
            end
            default:
            begin
                power_next = power_reg;
            end
        endcase
        if (fade_next)
        begin
            if (power_next && (int_next >= STEPS))
            begin
                int_next  = STEPS;
                fade_next = 1'b0;
            end
            else if (!power_next && (int_next == '0))
            begin
                fade_next = 1'b0;
            end
        end
    end

    // Desaturated channel level: c*255 + (255-s)*(255-c), plus the quotient
    // estimate and the remainder left by that estimate.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            chan[k]     = cfg.base_color[23 - 8*k -: 8];
            d_calc[k]   = {1'b0, chan[k], 8'd0} - D_W'(chan[k])
                        + D_W'(16'(8'd255 - cfg.saturation) * 16'(8'd255 - chan[k]));
            est_prod[k] = PROD_W'(num_reg[k][NUM_W-1:TOP_SH]) * PROD_W'(RECIP_C);
            fix_rem[k]  = num_reg[k] - NUM_W'(q_reg[k]) * DIV_N;
        end
    end

    // Sequencer and fade state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            power_reg     <= 1'b0;
            fade_reg      <= 1'b0;
            int_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        power_reg <= power_next;
                        fade_reg  <= fade_next;
                        int_reg   <= int_next;
                        tick_reg  <= tick_next;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_MUL3;
                ST_MUL3: state_reg <= ST_EST;
                ST_EST:  state_reg <= ST_FIX;
                ST_FIX:  state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Duty datapath: three multiply stages, a reciprocal estimate of the
    // quotient, then one compare and subtract that corrects it.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (state_reg == ST_MUL1)
            begin
                d_reg[k] <= d_calc[k];
            end
            if (state_reg == ST_MUL2)
            begin
                dv_reg[k] <= DV_W'(d_reg[k]) * DV_W'(cfg.brightness);
            end
            if (state_reg == ST_MUL3)
            begin
                num_reg[k] <= NUM_W'(dv_reg[k]) * NUM_W'(int_reg);
            end
            if (state_reg == ST_EST)
            begin
                q_reg[k] <= 8'(est_prod[k] >> EST_SH);
            end
            if (state_reg == ST_FIX)
            begin
                if (fix_rem[k] >= DIV_N)
                begin
                    q_reg[k] <= q_reg[k] + 1'b1;
                end
            end
            if (out_load)
            begin
                duty_reg[k] <= q_reg[k];
            end
        end
        if (out_load)
        begin
            out_power_reg <= power_reg;
            out_fade_reg  <= fade_reg;
            out_int_reg   <= 10'(int_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign red_duty        = duty_reg[0];
    assign green_duty      = duty_reg[1];
    assign blue_duty       = duty_reg[2];
    assign power_state     = out_power_reg;
    assign fading          = out_fade_reg;
    assign intensity_level = out_int_reg;

endmodule

// ===== sv/rfsc_checker.sv =====
// ----------------------------------------------------------------------------
// RGB fade controller port checker
// Watches the result channel for stable stalls and consistent fade status.
// ----------------------------------------------------------------------------
module rfsc_checker #(
    parameter int INTENSITY_STEPS = rfsc_pkg::DEF_INTENSITY_STEPS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] red_duty,
    input  logic [7:0] green_duty,
    input  logic [7:0] blue_duty,
    input  logic       power_state,
    input  logic       fading,
    input  logic [9:0] intensity_level
);
    localparam logic [9:0] FULL_LVL = 10'(INTENSITY_STEPS);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({red_duty, green_duty, blue_duty,
                        power_state, fading, intensity_level}))
        else $error("result changed while stalled");

    // A finished fade toward on leaves the intensity at full.
    a_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && power_state && !fading |-> intensity_level == FULL_LVL)
        else $error("lamp on and idle but intensity not full");

    // A finished fade toward off leaves everything dark.
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !power_state && !fading |-> intensity_level == 10'd0
            && red_duty == 8'd0 && green_duty == 8'd0 && blue_duty == 8'd0)
        else $error("lamp off and idle but output not dark");

    // No result is offered in the cycle after reset was seen low.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind rgb_fade_schedule_controller_top rfsc_checker #(
    .INTENSITY_STEPS (INTENSITY_STEPS)
) u_rfsc_checker (.*);
